FILE: rtl/range_redirect_read_splitter_top_assert.svh
// Assertion macros shared by the range redirect read splitter modules.
// No dependencies; included inside module bodies.
`ifndef RANGE_REDIRECT_READ_SPLITTER_TOP_ASSERT_SVH
`define RANGE_REDIRECT_READ_SPLITTER_TOP_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define RRS_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// Implication whose consequent is checked in the cycle after the antecedent.
`define RRS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`endif

FILE: rtl/rrs_pkg.sv
// Package for the range redirect read splitter: command, status and source codes
// and the item types that pass between the front end and the back end.
`timescale 1ns / 1ps
package rrs_pkg;
   localparam logic [1:0] MODE_READ = 2'd0;
   localparam logic [1:0] MODE_ADD  = 2'd1;
   localparam logic [1:0] MODE_DEL  = 2'd2;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_OVERLAP  = 2'd1;
   localparam logic [1:0] ST_NOTFOUND = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   localparam logic [1:0] SRC_DISK  = 2'd0;
   localparam logic [1:0] SRC_REDIR = 2'd1;
   localparam logic [1:0] SRC_MEM   = 2'd2;

   typedef struct packed {
      logic [1:0]  mode;
      logic [63:0] offset;
      logic [31:0] length;
      logic [63:0] redirect_offset;
      logic [15:0] memory_handle;
   } cmd_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [1:0]  source;
      logic [63:0] address;
      logic [15:0] buffer_id;
      logic [31:0] segment_length;
      logic        last;
   } rsp_type;
endpackage

FILE: rtl/rrs_cmd_fifo.sv
// Two-entry command queue that parts the accepting front from the table engine.
// Depends on rrs_pkg.
`timescale 1ns / 1ps
module rrs_cmd_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  rrs_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output rrs_pkg::cmd_type out_data
);
   import rrs_pkg::*;
   `include "range_redirect_read_splitter_top_assert.svh"

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wp_in  = push ? ~wp_ff : wp_ff;
      rp_in  = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= in_data;
      end
   end

   `RRS_ASSERT_IMP(a_cnt_range, 1'b1, cnt_ff != 2'd3, "queue count out of range")
   `RRS_ASSERT_NEXT(a_full_holds, cnt_ff == 2'd2 && !pop, cnt_ff == 2'd2, "full queue lost an entry")
   `RRS_ASSERT_IMP(a_ptrs_full, cnt_ff == 2'd2, wp_ff == rp_ff, "pointers disagree when full")
endmodule

FILE: rtl/rrs_engine.sv
// Table engine: holds the redirection entries, runs add and delete and splits
// reads into segments, one segment per pass. Depends on rrs_pkg.
`timescale 1ns / 1ps
module rrs_engine #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  rrs_pkg::cmd_type cmd,
   output logic             out_valid,
   input  logic             out_ready,
   output rrs_pkg::rsp_type out_data
);
   import rrs_pkg::*;
   `include "range_redirect_read_splitter_top_assert.svh"

   localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_EMIT = 3'd2;
   localparam logic [2:0] S_WAIT = 3'd3;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [63:0] start_ff [TABLE_ENTRIES];
   logic [31:0] size_ff [TABLE_ENTRIES];
   logic [63:0] target_ff [TABLE_ENTRIES];
   logic [15:0] handle_ff [TABLE_ENTRIES];

   logic [2:0]  state_ff, state_in;
   cmd_type     cmd_ff;
   logic [63:0] cur_ff, cur_in;
   logic [32:0] rem_ff, rem_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        hit_ff, hit_in;
   logic [IW-1:0] hidx_ff, hidx_in;
   logic [32:0] best_ff, best_in;
   logic        ovl_ff, ovl_in;
   logic        free_ok_ff, free_ok_in;
   logic [IW-1:0] free_ff, free_in;
   logic        del_ok_ff, del_ok_in;
   logic [IW-1:0] del_ff, del_in;
   logic        ovalid_ff, ovalid_in;
   rsp_type     odata_ff, odata_in;
   logic        wr_en;

   logic [63:0] e_start, e_target, d_in, d_bs, hit_ofs;
   logic [31:0] e_size;
   logic        e_live, last_idx, o_can;
   logic [32:0] avail, seg_len;

   assign o_can     = !ovalid_ff || out_ready;
   assign cmd_ready = (state_ff == S_IDLE);
   assign out_valid = ovalid_ff;
   assign out_data  = odata_ff;

   always_comb begin
      e_start  = start_ff[idx_ff];
      e_size   = size_ff[idx_ff];
      e_target = target_ff[hidx_ff];
      e_live   = valid_ff[idx_ff];
      last_idx = (idx_ff == IW'(TABLE_ENTRIES - 1));
      d_in     = cur_ff - e_start;
      d_bs     = e_start - cur_ff;
      hit_ofs  = cur_ff - start_ff[hidx_ff];
      avail    = {1'b0, size_ff[hidx_ff]} - hit_ofs[32:0];
      seg_len  = (avail < rem_ff) ? avail : rem_ff;

      state_in   = state_ff;
      valid_in   = valid_ff;
      cur_in     = cur_ff;
      rem_in     = rem_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      hidx_in    = hidx_ff;
      best_in    = best_ff;
      ovl_in     = ovl_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      del_ok_in  = del_ok_ff;
      del_in     = del_ff;
      ovalid_in  = ovalid_ff && !out_ready;
      odata_in   = odata_ff;
      wr_en      = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (cmd_valid) begin
               cur_in     = cmd.offset;
               rem_in     = {1'b0, cmd.length};
               idx_in     = '0;
               hit_in     = 1'b0;
               best_in    = {1'b0, cmd.length};
               ovl_in     = 1'b0;
               free_ok_in = 1'b0;
               del_ok_in  = 1'b0;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            if (cmd_ff.mode == MODE_READ) begin
               if (e_live && e_size != 32'd0 && !hit_ff) begin
                  if (d_in < {32'd0, e_size}) begin
                     hit_in  = 1'b1;
                     hidx_in = idx_ff;
                  end else if (d_bs < {31'd0, best_ff}) begin
                     best_in = d_bs[32:0];
                  end
               end
            end else if (cmd_ff.mode == MODE_ADD) begin
               if (e_live) begin
                  if (cmd_ff.offset == e_start
                      || (cmd_ff.offset - e_start) < {32'd0, e_size}
                      || (e_start - cmd_ff.offset) < {32'd0, cmd_ff.length}) begin
                     ovl_in = 1'b1;
                  end
               end else if (!free_ok_ff) begin
                  free_ok_in = 1'b1;
                  free_in    = idx_ff;
               end
            end else if (cmd_ff.mode == MODE_DEL) begin
               if (e_live && e_start == cmd_ff.offset && !del_ok_ff) begin
                  del_ok_in = 1'b1;
                  del_in    = idx_ff;
               end
            end
            if (last_idx) begin
               state_in = S_EMIT;
            end else begin
               idx_in = idx_ff + IW'(1);
            end
         end
         S_EMIT: begin
            if (o_can) begin
               ovalid_in = 1'b1;
               odata_in  = '0;
               odata_in.last = 1'b1;
               state_in  = S_WAIT;
               case (cmd_ff.mode)
                  MODE_READ: begin
                     if (rem_ff == 33'd0) begin
                        odata_in.address = cur_ff;
                     end else if (hit_ff) begin
                        odata_in.segment_length = seg_len[31:0];
                        if (handle_ff[hidx_ff] != 16'd0) begin
                           odata_in.source    = SRC_MEM;
                           odata_in.address   = hit_ofs;
                           odata_in.buffer_id = handle_ff[hidx_ff];
                        end else begin
                           odata_in.source  = SRC_REDIR;
                           odata_in.address = e_target + hit_ofs;
                        end
                        cur_in = cur_ff + {31'd0, seg_len};
                        rem_in = rem_ff - seg_len;
                        odata_in.last = (rem_ff == seg_len);
                     end else begin
                        odata_in.address        = cur_ff;
                        odata_in.segment_length = best_ff[31:0];
                        cur_in = cur_ff + {31'd0, best_ff};
                        rem_in = rem_ff - best_ff;
                        odata_in.last = (rem_ff == best_ff);
                     end
                     if (!odata_in.last) begin
                        idx_in   = '0;
                        hit_in   = 1'b0;
                        best_in  = rem_in;
                        state_in = S_SCAN;
                     end
                  end
                  MODE_ADD: begin
                     if (ovl_ff) begin
                        odata_in.status = ST_OVERLAP;
                     end else if (!free_ok_ff) begin
                        odata_in.status = ST_FULL;
                     end else begin
                        valid_in[free_ff] = 1'b1;
                        wr_en = 1'b1;
                     end
                  end
                  MODE_DEL: begin
                     if (del_ok_ff) begin
                        valid_in[del_ff] = 1'b0;
                     end else begin
                        odata_in.status = ST_NOTFOUND;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WAIT: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         valid_ff  <= '0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         ovalid_ff <= ovalid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      rem_ff     <= rem_in;
      idx_ff     <= idx_in;
      hit_ff     <= hit_in;
      hidx_ff    <= hidx_in;
      best_ff    <= best_in;
      ovl_ff     <= ovl_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
      del_ok_ff  <= del_ok_in;
      del_ff     <= del_in;
      odata_ff   <= odata_in;
      if (state_ff == S_IDLE && cmd_valid) begin
         cmd_ff <= cmd;
      end
      if (wr_en) begin
         start_ff[free_ff]  <= cmd_ff.offset;
         size_ff[free_ff]   <= cmd_ff.length;
         target_ff[free_ff] <= cmd_ff.redirect_offset;
         handle_ff[free_ff] <= cmd_ff.memory_handle;
      end
   end

   `RRS_ASSERT_IMP(a_stall_hold, ovalid_ff && !out_ready, ovalid_in && odata_in == odata_ff, "result changed under stall")
   `RRS_ASSERT_IMP(a_accept_idle, cmd_valid && cmd_ready, state_ff == S_IDLE, "command taken while busy")
   `RRS_ASSERT_NEXT(a_add_sets, wr_en, valid_ff[free_ff], "added entry not marked valid")
endmodule

FILE: rtl/range_redirect_read_splitter_top.sv
// Top level of the range redirect read splitter: a command queue feeding the table engine.
// Depends on rrs_pkg, rrs_cmd_fifo and rrs_engine.
`timescale 1ns / 1ps
// The block keeps up to TABLE_ENTRIES address range redirections and splits each read into
// ordered segments, the final beat of every command flagged by rsp_tlast. A two-entry queue
// takes commands while the engine works. The engine scans the table one entry per cycle, so
// add and delete each take one full scan of the table and a read takes one full scan per
// segment, each extended while a beat waits on rsp_tready; the serial table scan sets this
// timing.
module range_redirect_read_splitter_top #(
   parameter int TABLE_ENTRIES = 8
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // offset, length, redirect_offset, memory_handle
   input  logic [175:0] req_tdata,
   // mode
   input  logic [1:0]   req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status, address, buffer_id, segment_length, zero pad
   output logic [119:0] rsp_tdata,
   // source
   output logic [1:0]   rsp_tuser,
   output logic         rsp_tlast
);
   import rrs_pkg::*;

   cmd_type q_in, q_out;
   rsp_type r;
   logic    q_valid, q_ready;

   always_comb begin
      q_in.mode            = req_tuser;
      q_in.offset          = req_tdata[63:0];
      q_in.length          = req_tdata[95:64];
      q_in.redirect_offset = req_tdata[159:96];
      q_in.memory_handle   = req_tdata[175:160];
   end

   rrs_cmd_fifo u_fifo (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready), .in_data(q_in),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_out)
   );

   rrs_engine #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_engine (
      .clock(clock), .reset(reset),
      .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_out),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready), .out_data(r)
   );

   assign rsp_tdata = {6'd0, r.segment_length, r.buffer_id, r.address, r.status};
   assign rsp_tuser = r.source;
   assign rsp_tlast = r.last;
endmodule

FILE: test/range_redirect_read_splitter_top_tb.sv
// Testbench for range_redirect_read_splitter_top: adds, deletes and split reads checked
// beat by beat against a predictor of the redirection table. Depends on rrs_pkg and the RTL.
`timescale 1ns / 1ps
module range_redirect_read_splitter_top_tb;
   import rrs_pkg::*;

   localparam int ENTRIES = 8;
   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct {
      cmd_type cmd;
      bit      hold;
   } pending_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [175:0] req_tdata = '0;
   logic [1:0]   req_tuser = '0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [119:0] rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tlast;

   pending_type pending_cmds[$];
   rsp_type     expected_beats[$];
   cmd_type     current_cmd;
   bit          current_hold;
   int          gap_left = 0, burst_left = 0, settle_left = 0;
   int          fail_count = 0, beats_seen = 0, reads_sent = 0, table_ops_sent = 0;
   int          idle_cycles = 0;
   logic [15:0] stall_pattern = 16'hACE1;

   bit          tbl_valid[ENTRIES];
   logic [63:0] tbl_start[ENTRIES];
   logic [31:0] tbl_size[ENTRIES];
   logic [63:0] tbl_target[ENTRIES];
   logic [15:0] tbl_handle[ENTRIES];

   range_redirect_read_splitter_top #(.TABLE_ENTRIES(ENTRIES)) uut (.*);

   always #2 clock = ~clock;

   function automatic void push_beat(logic [1:0] status, logic [1:0] source,
                                     logic [63:0] address, logic [15:0] buffer_id,
                                     logic [31:0] seg_len, logic last);
      rsp_type beat;
      beat.status = status;
      beat.source = source;
      beat.address = address;
      beat.buffer_id = buffer_id;
      beat.segment_length = seg_len;
      beat.last = last;
      expected_beats.push_back(beat);
   endfunction

   function automatic bit ranges_clash(logic [63:0] a, logic [31:0] la,
                                       logic [63:0] b, logic [31:0] lb);
      logic [63:0] ab, ba;
      ab = a - b;
      ba = b - a;
      return (a == b) || (ab < {32'd0, lb}) || (ba < {32'd0, la});
   endfunction

   function automatic logic [1:0] table_add(cmd_type c);
      int free_slot;
      free_slot = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i]) begin
            if (ranges_clash(c.offset, c.length, tbl_start[i], tbl_size[i])) return ST_OVERLAP;
         end else if (free_slot < 0) begin
            free_slot = i;
         end
      end
      if (free_slot < 0) return ST_FULL;
      tbl_valid[free_slot] = 1'b1;
      tbl_start[free_slot] = c.offset;
      tbl_size[free_slot] = c.length;
      tbl_target[free_slot] = c.redirect_offset;
      tbl_handle[free_slot] = c.memory_handle;
      return ST_OK;
   endfunction

   function automatic logic [1:0] table_delete(logic [63:0] start);
      for (int i = 0; i < ENTRIES; i++) begin
         if (tbl_valid[i] && tbl_start[i] == start) begin
            tbl_valid[i] = 1'b0;
            return ST_OK;
         end
      end
      return ST_NOTFOUND;
   endfunction

   function automatic void split_read(logic [63:0] start, logic [31:0] count);
      logic [63:0] cur, rem, best, gap, hit_ofs, avail, seg;
      int hit;
      cur = start;
      rem = {32'd0, count};
      if (rem == 0) begin
         push_beat(ST_OK, SRC_DISK, cur, 16'd0, 32'd0, 1'b1);
         return;
      end
      while (rem != 0) begin
         hit = -1;
         best = rem;
         for (int i = 0; i < ENTRIES; i++) begin
            if (!tbl_valid[i] || tbl_size[i] == 0) continue;
            if (cur - tbl_start[i] < {32'd0, tbl_size[i]}) begin
               hit = i;
               break;
            end
            gap = tbl_start[i] - cur;
            if (gap < best) best = gap;
         end
         if (hit >= 0) begin
            hit_ofs = cur - tbl_start[hit];
            avail = {32'd0, tbl_size[hit]} - hit_ofs;
            seg = (avail < rem) ? avail : rem;
            if (tbl_handle[hit] != 0)
               push_beat(ST_OK, SRC_MEM, hit_ofs, tbl_handle[hit], seg[31:0], seg == rem);
            else
               push_beat(ST_OK, SRC_REDIR, tbl_target[hit] + hit_ofs, 16'd0, seg[31:0],
                  seg == rem);
         end else begin
            seg = best;
            push_beat(ST_OK, SRC_DISK, cur, 16'd0, seg[31:0], seg == rem);
         end
         cur += seg;
         rem -= seg;
      end
   endfunction

   function automatic void predict_command(cmd_type c);
      case (c.mode)
         MODE_READ: begin
            reads_sent++;
            split_read(c.offset, c.length);
         end
         MODE_ADD: begin
            table_ops_sent++;
            push_beat(table_add(c), SRC_DISK, 64'd0, 16'd0, 32'd0, 1'b1);
         end
         MODE_DEL: begin
            table_ops_sent++;
            push_beat(table_delete(c.offset), SRC_DISK, 64'd0, 16'd0, 32'd0, 1'b1);
         end
         default: push_beat(ST_OK, SRC_DISK, 64'd0, 16'd0, 32'd0, 1'b1);
      endcase
   endfunction

   function automatic cmd_type make_cmd(logic [1:0] mode, logic [63:0] offset,
                                        logic [31:0] length, logic [63:0] redirect_offset,
                                        logic [15:0] handle);
      cmd_type c;
      c.mode = mode;
      c.offset = offset;
      c.length = length;
      c.redirect_offset = redirect_offset;
      c.memory_handle = handle;
      return c;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void queue_cmd(cmd_type c, bit hold);
      pending_type p;
      p.cmd = c;
      p.hold = hold;
      pending_cmds.push_back(p);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_command(current_cmd);
         if (!req_tvalid || req_tready) begin
            if (pending_cmds.size() == 0 || gap_left > 0) begin
               req_tvalid <= 1'b0;
               if (gap_left > 0) gap_left <= gap_left - 1;
            end else if (pending_cmds[0].hold && (expected_beats.size() != 0 ||
                         (req_tvalid && req_tready))) begin
               req_tvalid <= 1'b0;
               settle_left <= 40;
            end else if (pending_cmds[0].hold && settle_left > 0) begin
               req_tvalid <= 1'b0;
               settle_left <= settle_left - 1;
            end else begin
               current_cmd = pending_cmds[0].cmd;
               void'(pending_cmds.pop_front());
               req_tvalid <= 1'b1;
               req_tdata <= {current_cmd.memory_handle, current_cmd.redirect_offset,
                             current_cmd.length, current_cmd.offset};
               req_tuser <= current_cmd.mode;
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         stall_pattern <= {stall_pattern[14:0],
                           stall_pattern[15] ^ stall_pattern[13] ^ stall_pattern[12] ^
                           stall_pattern[10]};
         rsp_tready <= stall_pattern[6] ? 1'b1 : (stall_pattern[2:0] != 3'd0);
         if (rsp_tvalid && rsp_tready) begin
            beats_seen++;
            got.status = rsp_tdata[1:0];
            got.source = rsp_tuser;
            got.address = rsp_tdata[65:2];
            got.buffer_id = rsp_tdata[81:66];
            got.segment_length = rsp_tdata[113:82];
            got.last = rsp_tlast;
            if (expected_beats.size() == 0) begin
               $display("%0t: unexpected beat, expected none, actual %p", $time, got);
               fail_count++;
            end else begin
               want = expected_beats.pop_front();
               if (got.status != want.status) begin
                  $display("%0t: status expected %0d actual %0d", $time, want.status,
                     got.status);
                  fail_count++;
               end
               if (got.source != want.source) begin
                  $display("%0t: source expected %0d actual %0d", $time, want.source,
                     got.source);
                  fail_count++;
               end
               if (got.address != want.address) begin
                  $display("%0t: address expected %h actual %h", $time, want.address,
                     got.address);
                  fail_count++;
               end
               if (got.buffer_id != want.buffer_id) begin
                  $display("%0t: buffer_id expected %h actual %h", $time, want.buffer_id,
                     got.buffer_id);
                  fail_count++;
               end
               if (got.segment_length != want.segment_length) begin
                  $display("%0t: segment_length expected %0d actual %0d", $time,
                     want.segment_length, got.segment_length);
                  fail_count++;
               end
               if (got.last != want.last) begin
                  $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
                  fail_count++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("range_redirect_read_splitter_top_tb: FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [63:0] base, start;
      logic [63:0] added_starts[$];
      int pick;
      for (int i = 0; i < ENTRIES; i++) tbl_valid[i] = 1'b0;

      // Directed part: empty table, extremes, overlap, full table, delete, wrap and mode three.
      queue_cmd(make_cmd(MODE_READ, 64'd100, 32'd0, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_READ, '1, '1, '1, '1), 1'b0);
      queue_cmd(make_cmd(MODE_DEL, 64'd5, 32'd0, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 32'd32, 64'h1000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd100, 32'd0, 64'h5000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd100, 32'd10, 64'h5000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd200, 32'd50, '1, 16'hFFFF), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd240, 32'd20, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd300, 32'd20, 64'h7000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd400, 32'd20, 64'd0, 16'h1234), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd500, 32'd20, 64'h9000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd600, 32'd20, 64'hA000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd700, 32'd20, 64'hB000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_ADD, 64'd800, 32'd20, 64'hC000, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_READ, 64'hFFFF_FFFF_FFFF_FFE0, 32'd900, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_READ, 64'd210, 32'd5, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_DEL, 64'd100, 32'd0, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_DEL, 64'd101, 32'd0, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_READ, 64'd0, '1, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(2'd3, '1, '1, '1, '1), 1'b1);
      for (int i = 0; i < 8; i++)
         queue_cmd(make_cmd(MODE_DEL, 64'd100 * (i + 2), 32'd0, 64'd0, 16'd0), 1'b0);
      queue_cmd(make_cmd(MODE_DEL, 64'hFFFF_FFFF_FFFF_FFF0, 32'd0, 64'd0, 16'd0), 1'b0);

      // Random part: table updates and reads inside a small window so that reads hit entries.
      base = ($urandom_range(0, 1) == 0) ? 64'hFFFF_FFFF_FFFF_F800 : rand64();
      for (int n = 0; n < 310; n++) begin
         pick = $urandom_range(0, 99);
         start = base + $urandom_range(0, 4095);
         if (pick < 8) begin
            queue_cmd(make_cmd(2'($urandom), rand64(), $urandom, rand64(),
               16'($urandom)), n % 100 == 50);
         end else if (pick < 40) begin
            added_starts.push_back(start);
            queue_cmd(make_cmd(MODE_ADD, start, $urandom_range(0, 400), rand64(),
               ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom)), n % 100 == 50);
         end else if (pick < 55 && added_starts.size() != 0) begin
            queue_cmd(make_cmd(MODE_DEL, added_starts[$urandom_range(0,
               added_starts.size() - 1)], $urandom, rand64(), 16'($urandom)), n % 100 == 50);
         end else if (pick < 58) begin
            queue_cmd(make_cmd(2'd3, rand64(), $urandom, rand64(), 16'($urandom)),
               n % 100 == 50);
         end else begin
            queue_cmd(make_cmd(MODE_READ, start - $urandom_range(0, 300),
               $urandom_range(0, 1500), rand64(), 16'($urandom)), n % 100 == 50);
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      wait (pending_cmds.size() == 0 && !req_tvalid);
      wait (expected_beats.size() == 0);
      repeat (200) @(posedge clock);
      $display("Covered %0d reads and %0d table updates, %0d result beats checked.",
         reads_sent, table_ops_sent, beats_seen);
      if (fail_count == 0 && expected_beats.size() == 0)
         $display("range_redirect_read_splitter_top_tb: PASS");
      else
         $display("range_redirect_read_splitter_top_tb: FAIL");
      $finish;
   end
endmodule

FILE: sim.f
+incdir+rtl
rtl/rrs_pkg.sv
rtl/rrs_cmd_fifo.sv
rtl/rrs_engine.sv
rtl/range_redirect_read_splitter_top.sv
test/range_redirect_read_splitter_top_tb.sv
